// ----- hdl/segment_intersection_assert.svh -----
// Assertion macros for the segment intersection pipeline.
`ifndef SEGMENT_INTERSECTION_ASSERT_SVH
`define SEGMENT_INTERSECTION_ASSERT_SVH

// Consequent in the same cycle.
`define SEGI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent in the cycle after the antecedent.
`define SEGI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/segi_pkg.sv -----
`default_nettype none
package segi_pkg;

  typedef enum logic [1:0] {
    VERDICT_NONE      = 2'd0,
    VERDICT_POINT     = 2'd1,
    VERDICT_COLLINEAR = 2'd2
  } verdict_t;

endpackage
`default_nettype wire

// ----- hdl/segment_intersection.sv -----
// Throughput: one transaction per cycle while the output is not stalled; five arithmetic stages, then one
// restoring-division stage per quotient bit, then the output register.
// A stalled output holds the whole pipeline in place.
// Reset: synchronous, active low; clears all stage valid bits, payload is not reset.
`default_nettype none
module segment_intersection #(
  parameter int COORD_BITS = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire signed [COORD_BITS-1:0]  in_ax0,
  input  wire signed [COORD_BITS-1:0]  in_ay0,
  input  wire signed [COORD_BITS-1:0]  in_ax1,
  input  wire signed [COORD_BITS-1:0]  in_ay1,
  input  wire signed [COORD_BITS-1:0]  in_bx0,
  input  wire signed [COORD_BITS-1:0]  in_by0,
  input  wire signed [COORD_BITS-1:0]  in_bx1,
  input  wire signed [COORD_BITS-1:0]  in_by1,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [1:0]                   out_verdict,
  output logic signed [COORD_BITS-1:0] out_cross_x,
  output logic signed [COORD_BITS-1:0] out_cross_y
);

  localparam int CW  = COORD_BITS;
  localparam int DW  = CW + 1;
  localparam int PW  = 2 * CW;
  localparam int MW  = 2 * CW + 1;
  localparam int EW  = 2 * CW + 2;
  localparam int SW  = 2 * CW + 3;
  localparam int QW  = 3 * CW + 2;
  localparam int NW  = 3 * CW + 3;
  localparam int RW  = 3 * CW + 4;

  typedef struct packed {
    logic [RW-1:0]    rem_x;
    logic [RW-1:0]    rem_y;
    logic [CW-1:0]    q_x;
    logic [CW-1:0]    q_y;
    logic [SW-1:0]    dmag;
    logic             neg_x;
    logic             neg_y;
    segi_pkg::verdict_t verdict;
  } div_t;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1
  logic                 v1_r;
  logic signed [CW-1:0] s1_ax0_r, s1_ay0_r, s1_ax1_r, s1_ay1_r;
  logic signed [CW-1:0] s1_bx0_r, s1_by0_r, s1_bx1_r, s1_by1_r;
  logic signed [DW-1:0] s1_a1_r, s1_b1_r, s1_a2_r, s1_b2_r;
  logic signed [PW-1:0] s1_p_r [4];
  logic                 s1_ovl_r;
  logic                 ovl_nxt;

  always_comb begin
    logic signed [CW-1:0] mnxa, mxxa, mnya, mxya, mnxb, mxxb, mnyb, mxyb;
    mnxa = (in_ax0 < in_ax1) ? in_ax0 : in_ax1;
    mxxa = (in_ax0 < in_ax1) ? in_ax1 : in_ax0;
    mnya = (in_ay0 < in_ay1) ? in_ay0 : in_ay1;
    mxya = (in_ay0 < in_ay1) ? in_ay1 : in_ay0;
    mnxb = (in_bx0 < in_bx1) ? in_bx0 : in_bx1;
    mxxb = (in_bx0 < in_bx1) ? in_bx1 : in_bx0;
    mnyb = (in_by0 < in_by1) ? in_by0 : in_by1;
    mxyb = (in_by0 < in_by1) ? in_by1 : in_by0;
    ovl_nxt = !((mxya < mnyb) || (mxyb < mnya) || (mxxa < mnxb) || (mxxb < mnxa));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
    if (en) begin
      s1_ax0_r <= in_ax0;
      s1_ay0_r <= in_ay0;
      s1_ax1_r <= in_ax1;
      s1_ay1_r <= in_ay1;
      s1_bx0_r <= in_bx0;
      s1_by0_r <= in_by0;
      s1_bx1_r <= in_bx1;
      s1_by1_r <= in_by1;
      s1_a1_r  <= DW'(in_ay1) - DW'(in_ay0);
      s1_b1_r  <= DW'(in_ax0) - DW'(in_ax1);
      s1_a2_r  <= DW'(in_by1) - DW'(in_by0);
      s1_b2_r  <= DW'(in_bx0) - DW'(in_bx1);
      s1_p_r[0] <= PW'(in_ax1) * PW'(in_ay0);
      s1_p_r[1] <= PW'(in_ax0) * PW'(in_ay1);
      s1_p_r[2] <= PW'(in_bx1) * PW'(in_by0);
      s1_p_r[3] <= PW'(in_bx0) * PW'(in_by1);
      s1_ovl_r <= ovl_nxt;
    end
  end

  // stage 2
  logic                 v2_r;
  logic signed [DW-1:0] s2_a1_r, s2_b1_r, s2_a2_r, s2_b2_r;
  logic signed [MW-1:0] s2_c1_r, s2_c2_r;
  logic signed [MW-1:0] s2_m_r [8];
  logic signed [EW-1:0] s2_d_r [2];
  logic                 s2_ovl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      s2_a1_r  <= s1_a1_r;
      s2_b1_r  <= s1_b1_r;
      s2_a2_r  <= s1_a2_r;
      s2_b2_r  <= s1_b2_r;
      s2_c1_r  <= MW'(s1_p_r[0]) - MW'(s1_p_r[1]);
      s2_c2_r  <= MW'(s1_p_r[2]) - MW'(s1_p_r[3]);
      s2_m_r[0] <= MW'(s1_a1_r) * MW'(s1_bx0_r);
      s2_m_r[1] <= MW'(s1_b1_r) * MW'(s1_by0_r);
      s2_m_r[2] <= MW'(s1_a1_r) * MW'(s1_bx1_r);
      s2_m_r[3] <= MW'(s1_b1_r) * MW'(s1_by1_r);
      s2_m_r[4] <= MW'(s1_a2_r) * MW'(s1_ax0_r);
      s2_m_r[5] <= MW'(s1_b2_r) * MW'(s1_ay0_r);
      s2_m_r[6] <= MW'(s1_a2_r) * MW'(s1_ax1_r);
      s2_m_r[7] <= MW'(s1_b2_r) * MW'(s1_ay1_r);
      s2_d_r[0] <= EW'(s1_a1_r) * EW'(s1_b2_r);
      s2_d_r[1] <= EW'(s1_a2_r) * EW'(s1_b1_r);
      s2_ovl_r <= s1_ovl_r;
    end
  end

  // stage 3
  logic                 v3_r;
  logic                 s3_rej_r;
  logic signed [SW-1:0] s3_den_r;
  logic signed [QW-1:0] s3_n_r [4];
  logic                 s3_ovl_r;
  logic                 rej_nxt;

  always_comb begin
    logic signed [SW-1:0] r1, r2, r3, r4;
    r3 = SW'(s2_m_r[0]) + SW'(s2_m_r[1]) + SW'(s2_c1_r);
    r4 = SW'(s2_m_r[2]) + SW'(s2_m_r[3]) + SW'(s2_c1_r);
    r1 = SW'(s2_m_r[4]) + SW'(s2_m_r[5]) + SW'(s2_c2_r);
    r2 = SW'(s2_m_r[6]) + SW'(s2_m_r[7]) + SW'(s2_c2_r);
    rej_nxt = ((r3 != '0) && (r4 != '0) && (r3[SW-1] == r4[SW-1])) ||
              ((r1 != '0) && (r2 != '0) && (r1[SW-1] == r2[SW-1]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
    if (en) begin
      s3_rej_r <= rej_nxt;
      s3_den_r <= SW'(s2_d_r[0]) - SW'(s2_d_r[1]);
      s3_n_r[0] <= QW'(s2_b1_r) * QW'(s2_c2_r);
      s3_n_r[1] <= QW'(s2_b2_r) * QW'(s2_c1_r);
      s3_n_r[2] <= QW'(s2_a2_r) * QW'(s2_c1_r);
      s3_n_r[3] <= QW'(s2_a1_r) * QW'(s2_c2_r);
      s3_ovl_r <= s2_ovl_r;
    end
  end

  // stage 4
  logic                 v4_r;
  logic signed [NW-1:0] s4_nx_r, s4_ny_r;
  logic [SW-1:0]        s4_dmag_r;
  logic                 s4_dneg_r;
  segi_pkg::verdict_t   s4_verdict_r;
  segi_pkg::verdict_t   verdict_nxt;

  always_comb begin
    if (s3_rej_r) begin
      verdict_nxt = segi_pkg::VERDICT_NONE;
    end else if (s3_den_r == '0) begin
      verdict_nxt = s3_ovl_r ? segi_pkg::VERDICT_COLLINEAR : segi_pkg::VERDICT_NONE;
    end else begin
      verdict_nxt = segi_pkg::VERDICT_POINT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
    if (en) begin
      s4_nx_r      <= NW'(s3_n_r[0]) - NW'(s3_n_r[1]);
      s4_ny_r      <= NW'(s3_n_r[2]) - NW'(s3_n_r[3]);
      s4_dmag_r    <= s3_den_r[SW-1] ? SW'(-s3_den_r) : SW'(s3_den_r);
      s4_dneg_r    <= s3_den_r[SW-1];
      s4_verdict_r <= verdict_nxt;
    end
  end

  // stage 5: apply half-denominator offset, take magnitudes
  logic                 dv_vld_r [CW+1];
  div_t                 dv_r [CW+1];
  div_t                 dv0_nxt;

  always_comb begin
    logic signed [SW:0]   hlf;
    logic signed [RW-1:0] nnx, nny;
    hlf = {1'b0, s4_dmag_r >> 1};
    nnx = s4_nx_r[NW-1] ? RW'(s4_nx_r) - RW'(hlf) : RW'(s4_nx_r) + RW'(hlf);
    nny = s4_ny_r[NW-1] ? RW'(s4_ny_r) - RW'(hlf) : RW'(s4_ny_r) + RW'(hlf);
    dv0_nxt.rem_x   = nnx[RW-1] ? RW'(-nnx) : RW'(nnx);
    dv0_nxt.rem_y   = nny[RW-1] ? RW'(-nny) : RW'(nny);
    dv0_nxt.q_x     = '0;
    dv0_nxt.q_y     = '0;
    dv0_nxt.dmag    = s4_dmag_r;
    dv0_nxt.neg_x   = nnx[RW-1] ^ s4_dneg_r;
    dv0_nxt.neg_y   = nny[RW-1] ^ s4_dneg_r;
    dv0_nxt.verdict = s4_verdict_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (en) begin
      dv_vld_r[0] <= v4_r;
    end
    if (en) begin
      dv_r[0] <= dv0_nxt;
    end
  end

  // restoring division, one quotient bit per stage, MSB first
  for (genvar k = 0; k < CW; k++) begin : g_div
    localparam int BIT = CW - 1 - k;
    div_t          stg_nxt;

    always_comb begin
      logic [RW-1:0] sh;
      stg_nxt = dv_r[k];
      sh      = RW'(dv_r[k].dmag) << BIT;
      if (dv_r[k].rem_x >= sh) begin
        stg_nxt.rem_x    = dv_r[k].rem_x - sh;
        stg_nxt.q_x[BIT] = 1'b1;
      end
      if (dv_r[k].rem_y >= sh) begin
        stg_nxt.rem_y    = dv_r[k].rem_y - sh;
        stg_nxt.q_y[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_vld_r[k+1] <= dv_vld_r[k];
      end
      if (en) begin
        dv_r[k+1] <= stg_nxt;
      end
    end
  end

  // output register
  logic out_valid_r;
  logic [1:0] out_verdict_r;
  logic signed [CW-1:0] out_x_r, out_y_r;
  logic pt;
  assign pt = (dv_r[CW].verdict == segi_pkg::VERDICT_POINT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_vld_r[CW];
    end
    if (en) begin
      out_verdict_r <= dv_r[CW].verdict;
      out_x_r <= !pt ? '0 : (dv_r[CW].neg_x ? -dv_r[CW].q_x : dv_r[CW].q_x);
      out_y_r <= !pt ? '0 : (dv_r[CW].neg_y ? -dv_r[CW].q_y : dv_r[CW].q_y);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;
  assign out_cross_x = out_x_r;
  assign out_cross_y = out_y_r;

`include "segment_intersection_assert.svh"

  `SEGI_ASSERT_NOW(a_zero_coords, out_valid && (out_verdict != segi_pkg::VERDICT_POINT), (out_cross_x == '0) && (out_cross_y == '0), "coordinates not zero without a crossing point")
  `SEGI_ASSERT_NEXT(a_drain, en && dv_vld_r[CW], out_valid, "last division stage lost its transaction")
  `SEGI_ASSERT_NEXT(a_point_kept, en && dv_vld_r[CW] && pt, out_verdict == segi_pkg::VERDICT_POINT, "point verdict lost at output")

endmodule
`default_nettype wire

// ----- bench/segment_intersection_test.sv -----
`default_nettype none
module segment_intersection_test;

  localparam int CB = 16;
  localparam int N_RANDOM = 1130;
  localparam int WATCHDOG = 4000;

  typedef logic signed [CB-1:0] coord_t;
  typedef logic signed [127:0] big_t;

  typedef struct {
    segi_pkg::verdict_t verdict;
    coord_t   x;
    coord_t   y;
  } crossing_t;

  typedef struct {
    coord_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  } seg_pair_t;

  function automatic coord_t round_quot(big_t num, big_t den);
    big_t mag, half, nn, q;
    begin
      mag = (den < 0) ? -den : den;
      half = mag >>> 1;
      nn = (num < 0) ? num - half : num + half;
      q = ((nn < 0) ? -nn : nn) / mag;
      if ((nn < 0) != (den < 0)) q = -q;
      return q[CB-1:0];
    end
  endfunction

  function automatic crossing_t predict_crossing(seg_pair_t p);
    big_t x1, y1, x2, y2, x3, y3, x4, y4;
    big_t a1, b1, c1, a2, b2, c2, r1, r2, r3, r4, den;
    crossing_t r;
    begin
      x1 = p.ax0; y1 = p.ay0; x2 = p.ax1; y2 = p.ay1;
      x3 = p.bx0; y3 = p.by0; x4 = p.bx1; y4 = p.by1;
      r.verdict = segi_pkg::VERDICT_NONE;
      r.x = '0;
      r.y = '0;
      a1 = y2 - y1; b1 = x1 - x2; c1 = x2 * y1 - x1 * y2;
      r3 = a1 * x3 + b1 * y3 + c1;
      r4 = a1 * x4 + b1 * y4 + c1;
      if (r3 != 0 && r4 != 0 && ((r3 < 0) == (r4 < 0))) return r;
      a2 = y4 - y3; b2 = x3 - x4; c2 = x4 * y3 - x3 * y4;
      r1 = a2 * x1 + b2 * y1 + c2;
      r2 = a2 * x2 + b2 * y2 + c2;
      if (r1 != 0 && r2 != 0 && ((r1 < 0) == (r2 < 0))) return r;
      den = a1 * b2 - a2 * b1;
      if (den == 0) begin
        if ((x1 > x2 ? x1 : x2) >= (x3 < x4 ? x3 : x4) &&
            (x3 > x4 ? x3 : x4) >= (x1 < x2 ? x1 : x2) &&
            (y1 > y2 ? y1 : y2) >= (y3 < y4 ? y3 : y4) &&
            (y3 > y4 ? y3 : y4) >= (y1 < y2 ? y1 : y2))
          r.verdict = segi_pkg::VERDICT_COLLINEAR;
        return r;
      end
      r.verdict = segi_pkg::VERDICT_POINT;
      r.x = round_quot(b1 * c2 - b2 * c1, den);
      r.y = round_quot(a2 * c1 - a1 * c2, den);
      return r;
    end
  endfunction

  class crossing_board;
    crossing_t pending[$];
    int mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void note_pair(seg_pair_t p);
      pending.push_back(predict_crossing(p));
    endfunction

    function void check_crossing(logic [1:0] v, coord_t x, coord_t y);
      crossing_t e;
      begin
        if (pending.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction v=%0d x=%0d y=%0d", v, x, y);
          return;
        end
        e = pending.pop_front();
        if (v !== e.verdict || x !== e.x || y !== e.y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp v=%0d x=%0d y=%0d got v=%0d x=%0d y=%0d",
                     e.verdict, e.x, e.y, v, x, y);
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic out_stall = 0;
  wire in_stall, out_valid;
  wire [1:0] out_verdict;
  wire signed [CB-1:0] out_cross_x, out_cross_y;
  seg_pair_t drv = '{default: '0};

  crossing_board board = new();
  int idle_cycles = 0;

  segment_intersection #(.COORD_BITS(CB)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_ax0(drv.ax0), .in_ay0(drv.ay0), .in_ax1(drv.ax1), .in_ay1(drv.ay1),
    .in_bx0(drv.bx0), .in_by0(drv.by0), .in_bx1(drv.bx1), .in_by1(drv.by1),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_verdict(out_verdict), .out_cross_x(out_cross_x), .out_cross_y(out_cross_y)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 16)) - coord_t'(8);
      2: return ($urandom_range(0, 1) ? coord_t'(16'sh7fff) : coord_t'(16'sh8000));
      default: return coord_t'($urandom_range(0, 400)) - coord_t'(200);
    endcase
  endfunction

  task automatic send_pair(seg_pair_t p);
    int gap;
    begin
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
      drv <= p;
      in_valid <= 1;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      board.note_pair(p);
    end
  endtask

  function automatic seg_pair_t rand_pair();
    seg_pair_t p;
    int m, k;
    begin
      m = $urandom_range(0, 3);
      p.ax0 = rand_coord(m); p.ay0 = rand_coord(m);
      p.ax1 = rand_coord(m); p.ay1 = rand_coord(m);
      p.bx0 = rand_coord(m); p.by0 = rand_coord(m);
      p.bx1 = rand_coord(m); p.by1 = rand_coord(m);
      case ($urandom_range(0, 7))
        0: begin
          k = int'($urandom_range(0, 6)) - 3;
          p.bx0 = coord_t'(p.ax0 + (p.ax1 - p.ax0) * k / 2);
          p.by0 = coord_t'(p.ay0 + (p.ay1 - p.ay0) * k / 2);
          p.bx1 = coord_t'(p.ax0 + (p.ax1 - p.ax0) * (k + 1));
          p.by1 = coord_t'(p.ay0 + (p.ay1 - p.ay0) * (k + 1));
        end
        1: begin p.bx1 = p.bx0 + (p.ax1 - p.ax0); p.by1 = p.by0 + (p.ay1 - p.ay0); end
        2: begin p.bx0 = p.ax1; p.by0 = p.ay1; end
        3: begin p.ax1 = p.ax0; p.ay1 = p.ay0; end
        default: ;
      endcase
      return p;
    end
  endfunction

  task automatic run_stimulus();
    seg_pair_t d[$];
    begin
      d.push_back('{0, 0, 4, 4, 0, 4, 4, 0});
      d.push_back('{0, 0, 3, 0, 0, 1, 1, 2});
      d.push_back('{0, 0, 4, 0, 2, 0, 6, 0});
      d.push_back('{0, 0, 2, 0, 5, 0, 7, 0});
      d.push_back('{0, 0, 4, 4, 2, 2, 2, 2});
      d.push_back('{1, 1, 1, 1, 1, 1, 1, 1});
      d.push_back('{0, 0, 4, 0, 2, 0, 2, 5});
      d.push_back('{0, 0, 3, 1, 0, 1, 3, 0});
      d.push_back('{0, 0, -3, -1, 0, -1, -3, 0});
      d.push_back('{0, 0, 1, 2, 1, 0, 0, 1});
      d.push_back('{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768});
      d.push_back('{32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767});
      d.push_back('{-32768, 0, 32767, 0, 0, -32768, 0, 32767});
      d.push_back('{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768});
      d.push_back('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767});
      d.push_back('{-1, -1, -1, -1, -1, -1, -1, -1});
      d.push_back('{0, 0, 7, 3, 0, 3, 7, 0});
      d.push_back('{0, 0, 4, 0, 0, 1, 4, 1});
      foreach (d[i]) send_pair(d[i]);
      repeat (N_RANDOM) send_pair(rand_pair());
      in_valid <= 0;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_crossing(out_verdict, out_cross_x, out_cross_y);
  end

  initial begin : stall_gen
    int n;
    @(posedge rst_n);
    forever begin
      n = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    run_stimulus();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
